@@ design/rmc_pkg.sv @@
package rmc_pkg;

   localparam int UDEG_W = 30;
   localparam int DEG_W = 10;
   localparam int MINS_W = 24;
   localparam int FRAC_W = 17;
   localparam int QUOT_W = 21;

   localparam logic [7:0] MAX_LINE = 8'd199;
   localparam logic [2:0] FRAC_DIGITS = 3'd5;

   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_DOT = 8'h2E;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic [3:0] FIELD_FIRST = 4'd1;
   localparam logic [3:0] FIELD_LAT = 4'd4;
   localparam logic [3:0] FIELD_LON = 4'd6;
   localparam logic [3:0] FIELD_MAX = 4'd15;

   localparam logic [2:0] TAG_FULL = 3'd6;
   localparam logic [2:0] TAG_MISS = 3'd7;

   localparam logic [DEG_W-1:0] HI_SAT = 10'd999;
   localparam logic [UDEG_W-1:0] UDEG_MAX = 30'd1000666666;

   localparam logic [24:0] RECIP_SIX = 25'd22369622;

   typedef struct packed {
      logic [DEG_W-1:0] deg;
      logic [MINS_W-1:0] mins;
   } coord_type;

   typedef struct packed {
      coord_type lat;
      coord_type lon;
   } fix_type;

   function automatic logic [7:0] tag_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h24;
         3'd1: c = 8'h47;
         3'd2: c = 8'h50;
         3'd3: c = 8'h52;
         3'd4: c = 8'h4D;
         3'd5: c = 8'h43;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [FRAC_W-1:0] frac_weight(input logic [2:0] pos);
      logic [FRAC_W-1:0] w;
      case (pos)
         3'd0: w = 17'd10000;
         3'd1: w = 17'd1000;
         3'd2: w = 17'd100;
         3'd3: w = 17'd10;
         3'd4: w = 17'd1;
         default: w = 17'd0;
      endcase
      return w;
   endfunction

   function automatic coord_type make_coord(input logic [DEG_W-1:0] hi,
                                            input logic [3:0] tens,
                                            input logic [3:0] units,
                                            input logic [FRAC_W-1:0] frac);
      coord_type r;
      logic [6:0] mm;
      mm = 7'({3'b000, tens} * 7'd10) + {3'b000, units};
      r.deg = hi;
      r.mins = MINS_W'({17'd0, mm} * 24'd100000) + MINS_W'(frac);
      return r;
   endfunction

endpackage

@@ design/nmea_rmc_position_extractor.sv @@
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_rx_byte
// rsp       out        rsp_valid / rsp_ready  rsp_latitude_udeg, rsp_longitude_udeg
//
// One byte is accepted per cycle while the parser is not stalled; each accepted byte is
// registered before it updates the parse state. A newline that ends a matching line
// yields a result through the input, snapshot, product and result registers.
// Synchronous reset clears the line state, the stored positions and all valid flags.
// A result waiting on rsp_ready stalls the stages behind it only once each is full.
module nmea_rmc_position_extractor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rmc_pkg::UDEG_W-1:0]  rsp_latitude_udeg,
   output logic [rmc_pkg::UDEG_W-1:0]  rsp_longitude_udeg
);
   import rmc_pkg::*;

   logic rx_vld_ff;
   logic [7:0] rx_ff;
   logic rx_take;
   logic fix_valid;
   logic fix_ready;
   fix_type fix_data;

   assign req_ready = !rx_vld_ff || rx_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_vld_ff <= 1'b0;
      end else if (req_ready) begin
         rx_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         rx_ff <= req_rx_byte;
      end
   end

   rmc_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .rx_data   (rx_ff),
      .rx_valid  (rx_vld_ff),
      .rx_take   (rx_take),
      .fix_valid (fix_valid),
      .fix_ready (fix_ready),
      .fix_data  (fix_data)
   );

   rmc_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .fix_valid (fix_valid),
      .fix_ready (fix_ready),
      .fix_data  (fix_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_lat   (rsp_latitude_udeg),
      .out_lon   (rsp_longitude_udeg)
   );

endmodule

@@ design/rmc_parse.sv @@
module rmc_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        rx_data,
   input  logic              rx_valid,
   output logic              rx_take,
   output logic              fix_valid,
   input  logic              fix_ready,
   output rmc_pkg::fix_type  fix_data
);
   import rmc_pkg::*;

   typedef enum logic [1:0] {PHASE_INT, PHASE_FRAC, PHASE_DONE} phase_type;

   logic [7:0] cnt_ff, cnt_in;
   logic [2:0] tag_ff, tag_in;
   logic tag_good_ff, tag_good_in;
   logic long_ff, long_in;
   logic [3:0] field_ff, field_in;
   logic [DEG_W-1:0] hi_ff, hi_in;
   logic [3:0] tens_ff, tens_in;
   logic [3:0] units_ff, units_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [2:0] fcnt_ff, fcnt_in;
   phase_type phase_ff, phase_in;
   coord_type lat_ff, lat_in;
   coord_type lon_ff, lon_in;
   logic snap_vld_ff;
   fix_type snap_ff, snap_in;

   logic stage_ready;
   logic emit;
   logic is_digit;
   logic [3:0] digit;
   logic [13:0] hi_shift;
   coord_type cur_coord;

   assign stage_ready = !snap_vld_ff || fix_ready;
   assign rx_take = rx_valid && stage_ready;
   assign fix_valid = snap_vld_ff;
   assign fix_data = snap_ff;

   assign is_digit = (rx_data >= CHAR_ZERO) && (rx_data <= CHAR_NINE);
   assign digit = rx_data[3:0];
   assign hi_shift = 14'({4'd0, hi_ff} * 14'd10) + {10'd0, tens_ff};
   assign cur_coord = make_coord(hi_ff, tens_ff, units_ff, frac_ff);

   always_comb begin
      cnt_in = cnt_ff;
      tag_in = tag_ff;
      tag_good_in = tag_good_ff;
      long_in = long_ff;
      field_in = field_ff;
      hi_in = hi_ff;
      tens_in = tens_ff;
      units_in = units_ff;
      frac_in = frac_ff;
      fcnt_in = fcnt_ff;
      phase_in = phase_ff;
      lat_in = lat_ff;
      lon_in = lon_ff;
      snap_in = snap_ff;
      emit = 1'b0;
      if (rx_take) begin
         if (rx_data == CHAR_LF) begin
            if (tag_good_ff && !long_ff) begin
               emit = 1'b1;
               if (field_ff == FIELD_LAT) begin
                  lat_in = cur_coord;
               end else if (field_ff == FIELD_LON) begin
                  lon_in = cur_coord;
               end
               snap_in.lat = lat_in;
               snap_in.lon = lon_in;
            end
            cnt_in = 8'd0;
            tag_in = 3'd0;
            tag_good_in = 1'b0;
            long_in = 1'b0;
            field_in = FIELD_FIRST;
            hi_in = '0;
            tens_in = 4'd0;
            units_in = 4'd0;
            frac_in = '0;
            fcnt_in = 3'd0;
            phase_in = PHASE_INT;
         end else if (!long_ff) begin
            if (cnt_ff >= MAX_LINE) begin
               long_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + 8'd1;
               if (tag_ff < TAG_FULL) begin
                  if (rx_data == tag_char(tag_ff)) begin
                     tag_in = tag_ff + 3'd1;
                     if (tag_ff == TAG_FULL - 3'd1) begin
                        tag_good_in = 1'b1;
                     end
                  end else begin
                     tag_in = TAG_MISS;
                  end
               end
               if (rx_data == CHAR_COMMA) begin
                  if (tag_good_ff) begin
                     if (field_ff == FIELD_LAT) begin
                        lat_in = cur_coord;
                     end else if (field_ff == FIELD_LON) begin
                        lon_in = cur_coord;
                     end
                  end
                  if (field_ff != FIELD_MAX) begin
                     field_in = field_ff + 4'd1;
                  end
                  hi_in = '0;
                  tens_in = 4'd0;
                  units_in = 4'd0;
                  frac_in = '0;
                  fcnt_in = 3'd0;
                  phase_in = PHASE_INT;
               end else begin
                  case (phase_ff)
                     PHASE_INT: begin
                        if (is_digit) begin
                           if (hi_shift > {4'd0, HI_SAT}) begin
                              hi_in = HI_SAT;
                              tens_in = 4'd9;
                              units_in = 4'd9;
                           end else begin
                              hi_in = hi_shift[DEG_W-1:0];
                              tens_in = units_ff;
                              units_in = digit;
                           end
                        end else if (rx_data == CHAR_DOT) begin
                           phase_in = PHASE_FRAC;
                        end else begin
                           phase_in = PHASE_DONE;
                        end
                     end
                     PHASE_FRAC: begin
                        if (is_digit) begin
                           if (fcnt_ff < FRAC_DIGITS) begin
                              frac_in = frac_ff
                                 + FRAC_W'({13'd0, digit} * frac_weight(fcnt_ff));
                              fcnt_in = fcnt_ff + 3'd1;
                           end
                        end else begin
                           phase_in = PHASE_DONE;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 8'd0;
         tag_ff <= 3'd0;
         tag_good_ff <= 1'b0;
         long_ff <= 1'b0;
         field_ff <= FIELD_FIRST;
         hi_ff <= '0;
         tens_ff <= 4'd0;
         units_ff <= 4'd0;
         frac_ff <= '0;
         fcnt_ff <= 3'd0;
         phase_ff <= PHASE_INT;
         lat_ff <= '0;
         lon_ff <= '0;
         snap_vld_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         tag_ff <= tag_in;
         tag_good_ff <= tag_good_in;
         long_ff <= long_in;
         field_ff <= field_in;
         hi_ff <= hi_in;
         tens_ff <= tens_in;
         units_ff <= units_in;
         frac_ff <= frac_in;
         fcnt_ff <= fcnt_in;
         phase_ff <= phase_in;
         lat_ff <= lat_in;
         lon_ff <= lon_in;
         if (stage_ready) begin
            snap_vld_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         snap_ff <= snap_in;
      end
   end

`ifndef SYNTHESIS
   a_tag_good: assert property (@(posedge clock) disable iff (reset)
      tag_good_ff |-> tag_ff == TAG_FULL)
      else $error("tag flagged good without a full match");
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_LINE)
      else $error("character count passed the line limit");
   a_snap_hold: assert property (@(posedge clock) disable iff (reset)
      snap_vld_ff && !fix_ready |=> snap_vld_ff && $stable(snap_ff))
      else $error("stalled position snapshot was lost or changed");
`endif

endmodule

@@ design/rmc_conv.sv @@
module rmc_conv (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fix_valid,
   output logic                         fix_ready,
   input  rmc_pkg::fix_type             fix_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [rmc_pkg::UDEG_W-1:0]   out_lat,
   output logic [rmc_pkg::UDEG_W-1:0]   out_lon
);
   import rmc_pkg::*;

   logic p_vld_ff;
   logic [QUOT_W-1:0] lat_q_ff, lon_q_ff;
   logic [UDEG_W-1:0] lat_dm_ff, lon_dm_ff;
   logic r_vld_ff;
   logic [UDEG_W-1:0] lat_ff, lon_ff;

   logic r_ready;
   logic p_ready;
   logic [48:0] lat_prod, lon_prod;
   logic [UDEG_W-1:0] lat_dm_in, lon_dm_in;

   assign r_ready = !r_vld_ff || out_ready;
   assign p_ready = !p_vld_ff || r_ready;
   assign fix_ready = p_ready;
   assign out_valid = r_vld_ff;
   assign out_lat = lat_ff;
   assign out_lon = lon_ff;

   // Minutes over sixty: the minutes are scaled by 1e5, so dividing by six
   // gives microdegrees; the reciprocal is exact for 24-bit minutes.
   assign lat_prod = {25'd0, fix_data.lat.mins} * {24'd0, RECIP_SIX};
   assign lon_prod = {25'd0, fix_data.lon.mins} * {24'd0, RECIP_SIX};
   assign lat_dm_in = {20'd0, fix_data.lat.deg} * 30'd1000000;
   assign lon_dm_in = {20'd0, fix_data.lon.deg} * 30'd1000000;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
         r_vld_ff <= 1'b0;
      end else begin
         if (p_ready) begin
            p_vld_ff <= fix_valid;
         end
         if (r_ready) begin
            r_vld_ff <= p_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_ready && fix_valid) begin
         lat_q_ff <= lat_prod[47:27];
         lon_q_ff <= lon_prod[47:27];
         lat_dm_ff <= lat_dm_in;
         lon_dm_ff <= lon_dm_in;
      end
      if (r_ready && p_vld_ff) begin
         lat_ff <= lat_dm_ff + {9'd0, lat_q_ff};
         lon_ff <= lon_dm_ff + {9'd0, lon_q_ff};
      end
   end

`ifndef SYNTHESIS
   a_lat_range: assert property (@(posedge clock) disable iff (reset)
      r_vld_ff |-> lat_ff <= UDEG_MAX)
      else $error("latitude out of range");
   a_lon_range: assert property (@(posedge clock) disable iff (reset)
      r_vld_ff |-> lon_ff <= UDEG_MAX)
      else $error("longitude out of range");
   a_prod_hold: assert property (@(posedge clock) disable iff (reset)
      p_vld_ff && !r_ready |=> p_vld_ff && $stable(lat_q_ff) && $stable(lon_q_ff))
      else $error("stalled product stage was lost or changed");
`endif

endmodule

@@ tb/nmea_rmc_position_extractor_test.sv @@
module nmea_rmc_position_extractor_test;
   import rmc_pkg::*;

   localparam string RMC_TAG = "$GPRMC";
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [16:0] WHOLE_SAT = 17'd99999;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_BYTES = 350;
   localparam int PHASE_FIXES = 3;

   typedef enum logic [1:0] {NUM_INT, NUM_FRAC, NUM_DONE} num_phase_type;

   typedef struct packed {
      logic [UDEG_W-1:0] lat;
      logic [UDEG_W-1:0] lon;
   } exp_fix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [UDEG_W-1:0] rsp_latitude_udeg;
   logic [UDEG_W-1:0] rsp_longitude_udeg;

   logic [7:0] pending_bytes[$];
   logic [7:0] line_buf[$];
   exp_fix_type expected_fixes[$];
   int fail_count = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int queued_bytes;
   int queued_fixes;

   logic [7:0] line_len = '0;
   logic [2:0] tag_pos = '0;
   logic tag_ok = 1'b0;
   logic overlong = 1'b0;
   logic [3:0] field_idx = FIELD_FIRST;
   logic [16:0] whole_digits = '0;
   logic [16:0] frac_digits = '0;
   logic [2:0] frac_count = '0;
   num_phase_type num_phase = NUM_INT;
   logic [UDEG_W-1:0] lat_store = '0;
   logic [UDEG_W-1:0] lon_store = '0;

   nmea_rmc_position_extractor i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_latitude_udeg(rsp_latitude_udeg),
      .rsp_longitude_udeg(rsp_longitude_udeg)
   );

   always #10 clock = ~clock;

   function automatic logic [UDEG_W-1:0] udeg_of(input logic [16:0] whole,
                                                input logic [16:0] frac,
                                                input logic [2:0] count);
      longint unsigned f;
      longint unsigned deg;
      longint unsigned mins;
      int i;
      f = frac;
      for (i = int'(count); i < int'(FRAC_DIGITS); i++) f = f * 10;
      deg = whole / 100;
      mins = longint'(whole % 100) * 100000 + f;
      return UDEG_W'(deg * 1000000 + mins * 1000000 / 6000000);
   endfunction

   function automatic void close_field();
      if (tag_ok && !overlong) begin
         if (field_idx == FIELD_LAT) lat_store = udeg_of(whole_digits, frac_digits, frac_count);
         else if (field_idx == FIELD_LON) lon_store = udeg_of(whole_digits, frac_digits, frac_count);
      end
   endfunction

   function automatic void clear_number();
      whole_digits = '0;
      frac_digits = '0;
      frac_count = '0;
      num_phase = NUM_INT;
   endfunction

   function automatic void clear_line();
      line_len = '0;
      tag_pos = '0;
      tag_ok = 1'b0;
      overlong = 1'b0;
      field_idx = FIELD_FIRST;
      clear_number();
   endfunction

   function automatic void parse_byte(input logic [7:0] c, output logic emit,
                                      output exp_fix_type fix);
      logic [20:0] v;
      logic is_digit;
      emit = 1'b0;
      fix = '0;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      if (c == CHAR_LF) begin
         if (tag_ok && !overlong) begin
            close_field();
            emit = 1'b1;
            fix.lat = lat_store;
            fix.lon = lon_store;
         end
         clear_line();
         return;
      end
      if (overlong) return;
      if (line_len >= MAX_LINE) begin
         overlong = 1'b1;
         return;
      end
      line_len++;
      if (tag_pos < TAG_FULL) begin
         if (c == 8'(RMC_TAG[tag_pos])) begin
            tag_pos++;
            if (tag_pos == TAG_FULL) tag_ok = 1'b1;
         end else begin
            tag_pos = TAG_MISS;
         end
      end
      if (c == CHAR_COMMA) begin
         close_field();
         if (field_idx < FIELD_MAX) field_idx++;
         clear_number();
         return;
      end
      case (num_phase)
         NUM_INT: begin
            if (is_digit) begin
               v = 21'(whole_digits) * 21'd10 + 21'(c - CHAR_ZERO);
               whole_digits = (v > 21'(WHOLE_SAT)) ? WHOLE_SAT : 17'(v);
            end else if (c == CHAR_DOT) begin
               num_phase = NUM_FRAC;
            end else begin
               num_phase = NUM_DONE;
            end
         end
         NUM_FRAC: begin
            if (is_digit) begin
               if (frac_count < FRAC_DIGITS) begin
                  frac_digits = frac_digits * 17'd10 + 17'(c - CHAR_ZERO);
                  frac_count++;
               end
            end else begin
               num_phase = NUM_DONE;
            end
         end
         default: ;
      endcase
   endfunction

   // A request stays on the bus until it is taken; the next one may follow at once.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      logic emit;
      exp_fix_type fix;
      exp_fix_type want;
      if (reset) begin
         clear_line();
         lat_store = '0;
         lon_store = '0;
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_rx_byte, emit, fix);
            if (emit) expected_fixes.push_back(fix);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_fixes.size() == 0) begin
               $error("unexpected fix: latitude_udeg %0d, longitude_udeg %0d",
                      rsp_latitude_udeg, rsp_longitude_udeg);
               fail_count++;
            end else begin
               want = expected_fixes.pop_front();
               if (rsp_latitude_udeg !== want.lat) begin
                  $error("latitude_udeg: expected %0d, actual %0d", want.lat, rsp_latitude_udeg);
                  fail_count++;
               end
               if (rsp_longitude_udeg !== want.lon) begin
                  $error("longitude_udeg: expected %0d, actual %0d", want.lon,
                         rsp_longitude_udeg);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("nmea_rmc_position_extractor_test failed");
         $finish;
      end
   end

   task automatic add_byte(input logic [7:0] b);
      line_buf.push_back(b);
   endtask

   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) line_buf.push_back(8'(s[i]));
   endtask

   task automatic add_digits(input int n);
      repeat (n) line_buf.push_back(CHAR_ZERO + 8'($urandom_range(9)));
   endtask

   task automatic pad_line(input int len);
      while (line_buf.size() < len) line_buf.push_back(8'h41 + 8'($urandom_range(25)));
   endtask

   task automatic add_odd_byte();
      logic [7:0] b;
      case ($urandom_range(5))
         0: b = 8'h2D;
         1: b = 8'h20;
         2: b = CHAR_DOT;
         3: b = CHAR_CR;
         default: begin
            b = 8'($urandom_range(254));
            if (b >= CHAR_LF) b++;
         end
      endcase
      line_buf.push_back(b);
   endtask

   task automatic end_line();
      int i;
      logic tag_seen;
      tag_seen = (line_buf.size() >= 6) && (line_buf.size() <= MAX_LINE);
      for (i = 0; i < 6 && tag_seen; i++) if (line_buf[i] != 8'(RMC_TAG[i])) tag_seen = 1'b0;
      if (tag_seen) queued_fixes++;
      queued_bytes += line_buf.size() + 1;
      foreach (line_buf[i]) pending_bytes.push_back(line_buf[i]);
      pending_bytes.push_back(CHAR_LF);
      line_buf.delete();
   endtask

   task automatic add_coordinate(input int usual_digits);
      int whole_n;
      int frac_n;
      int odd_at;
      whole_n = ($urandom_range(99) < 80) ? usual_digits : $urandom_range(7);
      frac_n = $urandom_range(7);
      odd_at = ($urandom_range(99) < 10) ? $urandom_range(2) : -1;
      if (odd_at == 0) add_odd_byte();
      add_digits(whole_n);
      if (odd_at == 1) add_odd_byte();
      if ($urandom_range(99) < 85) begin
         add_byte(CHAR_DOT);
         add_digits(frac_n);
      end
      if (odd_at == 2) add_odd_byte();
   endtask

   task automatic add_random_line();
      int kind;
      int last_field;
      int f;
      int b;
      kind = $urandom_range(99);
      if (kind < 8) begin
         repeat ($urandom_range(1, 30)) pending_bytes.push_back(8'($urandom_range(255)));
         pending_bytes.push_back(CHAR_LF);
         return;
      end
      if (kind < 12) begin
         add_text(RMC_TAG.substr(0, $urandom_range(5) - 1));
      end else begin
         add_text(RMC_TAG);
         if (kind < 22) begin
            b = $urandom_range(5);
            if ($urandom_range(1) == 0) line_buf.push_front(8'h24);
            else line_buf[b] = line_buf[b] ^ (8'(1) << $urandom_range(7));
         end
         last_field = ($urandom_range(99) < 75) ? 12 : $urandom_range(1, 12);
         for (f = 2; f <= last_field; f++) begin
            add_byte(CHAR_COMMA);
            case (f)
               4: add_coordinate(4);
               6: add_coordinate(5);
               5: add_text(($urandom_range(1) != 0) ? "N" : "S");
               7: add_text(($urandom_range(1) != 0) ? "E" : "W");
               default: if ($urandom_range(3) != 0) add_digits($urandom_range(6));
            endcase
         end
         if (kind == 95) pad_line(MAX_LINE);
         else if (kind > 95) pad_line(MAX_LINE + $urandom_range(1, 16));
      end
      end_line();
   endtask

   task automatic add_directed_lines();
      add_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A");
      end_line();
      add_text("$GPRMC,,V,,,,,,,,,,N*53");
      end_line();
      add_text("$GPRMC,0,A,9999999999.123456789,S,00000012345.9999999,W");
      end_line();
      add_text("$GPRMC,1,A,0075.5,N,1-23.4,E");
      add_byte(CHAR_CR);
      end_line();
      add_text("$GPRMC,1,A,12.3.4,N");
      end_line();
      add_text("$GPRMC,1,A, 4512.5,N,.5,E");
      end_line();
      add_text("x$GPRMC,1,A,1234.5,N,1234.5,E");
      end_line();
      add_text("$GPRM");
      end_line();
      end_line();
      add_text("$GPRMC,,,3000,,4000");
      repeat (14) add_text(",7");
      end_line();
      add_text("$GPRMC,1,A,1111.1,N,2222.2,E,");
      pad_line(MAX_LINE + 1);
      end_line();
      add_text("$GPRMC");
      end_line();
      add_text("$GPRMC,1,A,3333.3,N,4444.4,E,");
      pad_line(MAX_LINE);
      end_line();
      add_text("$GPRMC,");
      add_byte(8'h00);
      add_byte(CHAR_COMMA);
      add_byte(8'hFF);
      add_text(",4500.00000,N,");
      add_byte(8'h80);
      add_text("9000.5,W");
      end_line();
   endtask

   initial begin
      int phase;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < 4; phase++) begin
         @(negedge clock);
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 45; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 45; end
            default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
         endcase
         queued_bytes = 0;
         queued_fixes = 0;
         if (phase == 0) add_directed_lines();
         while (queued_bytes < PHASE_BYTES || queued_fixes < PHASE_FIXES) add_random_line();
         do @(negedge clock);
         while (pending_bytes.size() != 0 || req_valid || expected_fixes.size() != 0);
      end
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("nmea_rmc_position_extractor_test passed");
      end else begin
         $display("nmea_rmc_position_extractor_test failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/rmc_pkg.sv
design/rmc_parse.sv
design/rmc_conv.sv
design/nmea_rmc_position_extractor.sv
tb/nmea_rmc_position_extractor_test.sv
